// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, round constants and bit functions shared by the SHA-256 core.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [0:7][31:0] t_hash;

    typedef struct packed {
        logic shift;   // advance the schedule line by one word
        logic ext;     // shift in the external word instead of the expanded one
    } t_sched_ctl;

    typedef struct packed {
        logic load;    // copy the hash words into a..h
        logic step;    // run one compression round
    } t_round_ctl;

    localparam t_word MARKER_WORD = 32'h8000_0000;
    localparam logic [3:0] LEN_HI_POS = 4'd14;

    localparam t_hash INIT_HASH = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic t_word big_sigma0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // Final word with fewer than four valid bytes: clear the rest, insert marker.
    function automatic t_word pad_short_word(t_word w, logic [2:0] nb);
        t_word r;
        case (nb)
            3'd0:    r = MARKER_WORD;
            3'd1:    r = {w[31:24], 24'h80_0000};
            3'd2:    r = {w[31:16], 16'h8000};
            3'd3:    r = {w[31:8], 8'h80};
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sha256_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_sched
// Sixteen-word message schedule line: collects block words, then expands.
// ----------------------------------------------------------------------------
module sha256_sched
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  t_sched_ctl i_ctl,
    input  t_word      i_word,
    output t_word      o_w
);

    t_word r_w [16];
    t_word expanded;

    // W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
    assign expanded = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign o_w = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_ctl.ext ? i_word : expanded;
        end
    end

endmodule

// ===== rtl/sha256_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_round
// Working variables a..h and the single shared compression round.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  t_round_ctl i_ctl,
    input  t_hash      i_hash,
    input  t_word      i_w,
    input  t_word      i_k,
    output t_hash      o_vars
);

    t_hash r_v;
    t_word t1;
    t_word t2;
    t_word choose;
    t_word major;

    assign choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_sigma1(r_v[4]) + choose + i_k + i_w;
    assign t2     = big_sigma0(r_v[0]) + major;
    assign o_vars = r_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_hash;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule

// ===== rtl/sha256_hash_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_core
// Streaming SHA-256 hasher with one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the core is idle. The sixteenth word of
// a block starts a compression that holds o_stall high while the single round
// unit runs the 64 rounds and then folds a..h into the hash. On a final word
// the core generates the marker, zero fill and length words itself, one per
// cycle outside compressions, compressing one or two more blocks, and then
// offers the eight digest words as eight output transactions, index 0 first.
// After the eighth is taken the core starts a new message from the initial
// values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_hash_core
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [5:0]  r_round, n_round;
    logic [63:0] r_bitlen, n_bitlen;
    logic        r_mark, n_mark;
    logic        r_len, n_len;
    logic        r_done, n_done;
    logic        r_pad, n_pad;
    logic [2:0]  r_idx, n_idx;
    t_hash       r_hash, n_hash;

    t_hash       vars;
    t_word       sched_w;
    t_word       absorb_word;
    logic        absorb;
    logic        in_fire;
    logic        out_fire;
    logic [2:0]  nb_sat;
    t_sched_ctl  sched_ctl;
    t_round_ctl  round_ctl;

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_digest_word  = r_hash[r_idx];
    assign o_digest_index = r_idx;
    assign o_digest_last  = (r_idx == 3'd7);

    assign in_fire  = i_valid && !o_stall;
    assign out_fire = o_valid && !i_stall;
    assign nb_sat   = i_valid_bytes[2] ? 3'd4 : i_valid_bytes;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_round  = r_round;
        n_bitlen = r_bitlen;
        n_mark   = r_mark;
        n_len    = r_len;
        n_done   = r_done;
        n_pad    = r_pad;
        n_idx    = r_idx;
        n_hash   = r_hash;
        absorb      = 1'b0;
        absorb_word = i_message_word;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    absorb = 1'b1;
                    if (!i_final_word) begin
                        n_bitlen = r_bitlen + 64'd32;
                    end else begin
                        n_bitlen = r_bitlen + {58'b0, nb_sat, 3'b000};
                        n_pad    = 1'b1;
                        n_state  = ST_PAD;
                        if (i_valid_bytes[2]) begin
                            n_mark = 1'b1;
                        end else begin
                            absorb_word = pad_short_word(i_message_word, nb_sat);
                        end
                    end
                end
            end
            ST_PAD: begin
                absorb = 1'b1;
                if (r_mark) begin
                    absorb_word = MARKER_WORD;
                    n_mark      = 1'b0;
                end else if (r_len) begin
                    absorb_word = r_bitlen[31:0];
                    n_len       = 1'b0;
                    n_done      = 1'b1;
                end else if (r_pos == LEN_HI_POS) begin
                    absorb_word = r_bitlen[63:32];
                    n_len       = 1'b1;
                end else begin
                    absorb_word = '0;
                end
            end
            ST_COMP: begin
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + vars[i];
                end
                if (r_done) begin
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_hash   = INIT_HASH;
                        n_bitlen = '0;
                        n_pad    = 1'b0;
                        n_done   = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // The sixteenth word of a block starts a compression.
        if (absorb) begin
            n_pos = r_pos + 4'd1;
            if (r_pos == 4'd15) begin
                n_state = ST_COMP;
                n_round = '0;
            end
        end
    end

    assign sched_ctl.shift = absorb || (r_state == ST_COMP);
    assign sched_ctl.ext   = absorb;
    assign round_ctl.load  = absorb && (r_pos == 4'd15);
    assign round_ctl.step  = (r_state == ST_COMP);

    sha256_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (absorb_word),
        .o_w    (sched_w)
    );

    sha256_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (round_ctl),
        .i_hash (r_hash),
        .i_w    (sched_w),
        .i_k    (ROUND_K[r_round]),
        .o_vars (vars)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_round  <= '0;
            r_bitlen <= '0;
            r_mark   <= 1'b0;
            r_len    <= 1'b0;
            r_done   <= 1'b0;
            r_pad    <= 1'b0;
            r_idx    <= '0;
            r_hash   <= INIT_HASH;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_bitlen <= n_bitlen;
            r_mark   <= n_mark;
            r_len    <= n_len;
            r_done   <= n_done;
            r_pad    <= n_pad;
            r_idx    <= n_idx;
            r_hash   <= n_hash;
        end
    end

    `ASSERT_SAME(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall, "digest offered while input open")
    `ASSERT_SAME(a_round_idle, i_clk, i_rst_n, r_state != ST_COMP, r_round == 6'd0, "round count not at zero outside compression")
    `ASSERT_SAME(a_block_aligned, i_clk, i_rst_n, r_state == ST_COMP, r_pos == 4'd0, "compression started on a partial block")
    `ASSERT_NEXT(a_msg_restart, i_clk, i_rst_n, out_fire && o_digest_last, !o_stall && r_bitlen == 64'd0, "core not reset after last digest word")

endmodule

// ===== test/sha256_hash_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_core_tb
// Streams messages into the SHA-256 core with random idle and stall cycles.
// An in-bench hash model predicts the eight digest words of every message,
// and each digest transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module sha256_hash_core_tb;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_ITEMS = 45;
    localparam int TAIL_CYCLES = 100;

    localparam bit [31:0] PAD_MARKER = 32'h8000_0000;
    localparam int        LEN_SLOT   = 14;

    localparam bit [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam bit [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    class digest_scoreboard;
        bit [31:0]    state_h [8];
        bit [31:0]    sched [16];
        int unsigned  word_count;
        bit [63:0]    message_bits;
        t_digest_beat digest_q [$];
        int unsigned  errors;

        function new();
            foreach (sched[i]) sched[i] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            state_h      = SHA_IV;
            word_count   = 0;
            message_bits = '0;
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction

        function bit [31:0] ror(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void run_rounds();
            bit [31:0] v [8];
            bit [31:0] w, x15, x2, e, a, t1, t2;
            v = state_h;
            for (int t = 0; t < 64; t++) begin
                if (t < 16) begin
                    w = sched[t];
                end else begin
                    // expand the schedule in place, sixteen words deep
                    x15 = sched[(t + 1) % 16];
                    x2  = sched[(t + 14) % 16];
                    w = sched[t % 16] + sched[(t + 9) % 16]
                        + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
                        + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
                    sched[t % 16] = w;
                end
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                     + ((e & v[5]) ^ (~e & v[6])) + SHA_K[t] + w;
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                     + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (state_h[i]) state_h[i] = state_h[i] + v[i];
        endfunction

        function void push_block_word(bit [31:0] w);
            sched[word_count] = w;
            word_count = (word_count + 1) % 16;
            if (word_count == 0) begin
                run_rounds();
            end
        endfunction

        function void note_word(bit [31:0] word, bit [2:0] nbytes, bit is_final);
            int unsigned n;
            bit [31:0]   keep;
            t_digest_beat beat;
            n = (nbytes > 4) ? 4 : nbytes;
            if (!is_final) begin
                // short counts on a non-final word still hash all four bytes
                message_bits = message_bits + 64'd32;
                push_block_word(word);
                return;
            end
            message_bits = message_bits + 64'(n * 8);
            if (n == 4) begin
                push_block_word(word);
                push_block_word(PAD_MARKER);
            end else begin
                keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
                push_block_word((word & keep) | (PAD_MARKER >> (8 * n)));
            end
            while (word_count != LEN_SLOT) push_block_word(32'h0);
            push_block_word(message_bits[63:32]);
            push_block_word(message_bits[31:0]);
            for (int i = 0; i < 8; i++) begin
                beat.word  = state_h[i];
                beat.index = 3'(i);
                beat.last  = (i == 7);
                digest_q = {digest_q, beat};
            end
            restart();
        endfunction

        function void report(string what, t_digest_beat exp_b, t_digest_beat act_b);
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("%0t: %s: expected word %h index %0d last %0d, got word %h index %0d last %0d",
                         $realtime, what, exp_b.word, exp_b.index, exp_b.last,
                         act_b.word, act_b.index, act_b.last);
            end
        endfunction

        function void check_word(bit [31:0] word, bit [2:0] index, bit last);
            t_digest_beat act_b;
            t_digest_beat exp_b;
            act_b.word  = word;
            act_b.index = index;
            act_b.last  = last;
            if (digest_q.size() == 0) begin
                report("digest with nothing pending", '0, act_b);
                return;
            end
            exp_b = digest_q.pop_front();
            if (act_b.word !== exp_b.word) report("digest word mismatch", exp_b, act_b);
            if (act_b.index !== exp_b.index) report("digest index mismatch", exp_b, act_b);
            if (act_b.last !== exp_b.last) report("digest last mismatch", exp_b, act_b);
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic [2:0]  i_valid_bytes  = '0;
    logic        i_final_word   = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_digest_index;
    logic        o_digest_last;

    int unsigned      send_idle_pct  = 13;
    int unsigned      recv_stall_pct = 51;
    int unsigned      cycle_count    = 0;
    digest_scoreboard sb;

    sha256_hash_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_final_word   (i_final_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_digest_last  (o_digest_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_word(o_digest_word, o_digest_index, o_digest_last);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sha256_hash_core_tb: done, errors");
            $finish;
        end
    end

    // Entered and left just after a falling edge; valid stays high between
    // back-to-back transactions.
    task automatic send_word(bit [31:0] word, bit [2:0] nbytes, bit is_final);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_message_word <= word;
        i_valid_bytes  <= nbytes;
        i_final_word   <= is_final;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(word, nbytes, is_final);
        @(negedge i_clk);
    endtask

    // Hold the input side until every predicted digest word has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned body;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty message, then single-word messages of every byte count
        send_word($urandom, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'h0000_0000, 3'd2, 1'b1);
        send_word($urandom, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word($urandom, 3'd7, 1'b1);
        // short and oversized counts on non-final words
        send_word($urandom, 3'd2, 1'b0);
        send_word($urandom, 3'd5, 1'b0);
        send_word($urandom, 3'd6, 1'b1);
        // full final word at slot 13 pushes the length into an extra block
        repeat (13) send_word($urandom, 3'd4, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        drain();

        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 13 : (phase == 1) ? 51 : 0;
            recv_stall_pct = (phase == 0) ? 51 : (phase == 1) ? 13 : 0;
            while (sent < (phase + 1) * PHASE_ITEMS) begin
                body = ($urandom_range(5) == 0) ? $urandom_range(14, 40)
                                                : $urandom_range(0, 17);
                repeat (body) begin
                    send_word($urandom,
                              ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4,
                              1'b0);
                    sent++;
                end
                send_word($urandom, 3'($urandom_range(7)), 1'b1);
                sent++;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sha256_hash_core_tb: done, clean");
        end else begin
            $display("sha256_hash_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_round.sv
rtl/sha256_hash_core.sv
test/sha256_hash_core_tb.sv
